>>> design/secw_pkg.sv
// Shared types and constants for the sorted edge list to CSR writer.
// No dependencies.
package secw_pkg;

  localparam int unsigned MAX_FILL_DEF = 62;
  localparam int unsigned DEG_W        = 31;
  localparam int unsigned IDX_W        = 48;
  localparam int unsigned ID_W         = 32;
  localparam int unsigned ADDR_W       = 64;
  localparam int unsigned CFG_IDX_W    = 3;

  localparam logic [DEG_W-1:0] DEG_MAX = {DEG_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_EDGE_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_BASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PART_VERTS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PART_STRIDE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EDGES_SPLIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VERTS_SPLIT = 3'd5;

  localparam logic CMD_EDGE   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // input beat held in the front/back queue
  typedef struct packed {
    logic            cmd;
    logic [ID_W-1:0] src;
    logic [ID_W-1:0] dst;
  } item_t;

  // one result beat
  typedef struct packed {
    logic              is_vertex;
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   ref_id;
    logic [IDX_W-1:0]  list_start;
    logic [DEG_W-1:0]  degree;
    logic              run_last;
    logic              fill_cut;
  } res_t;

endpackage

>>> design/secw_fifo.sv
// Small two-entry queue between the front and the back of the writer.
// Depends on secw_pkg.
module secw_fifo import secw_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  item_t wr_data,
  output logic  rd_valid,
  input  logic  rd_ready,
  output item_t rd_data
);
  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) wp_r <= ~wp_r;
      if (do_rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end
endmodule

>>> design/secw_divider.sv
// Iterative 32-bit unsigned divider, one quotient bit per cycle.
// Depends on secw_pkg.
module secw_divider import secw_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [ID_W-1:0] dividend,
  input  logic [ID_W-1:0] divisor,
  output logic            done,
  output logic [ID_W-1:0] quot,
  output logic [ID_W-1:0] rem
);
  localparam int unsigned CNT_W = $clog2(ID_W + 1);

  logic [ID_W-1:0]  q_r, d_r;
  logic [ID_W:0]    r_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [ID_W:0]    trial;
  logic [ID_W:0]    diff;

  assign trial = {r_r[ID_W-1:0], q_r[ID_W-1]};
  assign diff  = trial - {1'b0, d_r};
  assign done  = busy_r && (cnt_r == '0);
  assign quot  = q_r;
  assign rem   = r_r[ID_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(ID_W);
      q_r    <= dividend;
      d_r    <= divisor;
      r_r    <= '0;
    end else if (busy_r && cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
      if (!diff[ID_W]) begin
        r_r <= diff;
        q_r <= {q_r[ID_W-2:0], 1'b1};
      end else begin
        r_r <= trial;
        q_r <= {q_r[ID_W-2:0], 1'b0};
      end
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end
endmodule

>>> design/secw_back.sv
// Back end: runs one queued item through the CSR state and emits result beats.
// Depends on secw_pkg and secw_divider.
module secw_back import secw_pkg::*; #(
  parameter int unsigned MAX_FILL = MAX_FILL_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  output logic              item_ready,
  input  item_t             item,
  input  logic [ADDR_W-1:0] edge_base,
  input  logic [ADDR_W-1:0] vertex_base,
  input  logic [ID_W-1:0]   part_vertices,
  input  logic [ADDR_W-1:0] part_stride,
  input  logic              edges_split,
  input  logic              vertices_split,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);
  localparam int unsigned FC_W = $clog2(MAX_FILL + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIVA, S_DIVB, S_VTX, S_VDIV, S_VMUL, S_VOUT, S_FILL,
    S_EMUL, S_EOUT, S_WAIT
  } state_t;

  state_t            state_r;
  item_t             it_r;
  logic              started_r;
  logic [ID_W-1:0]   cur_src_r, max_dest_r;
  logic [IDX_W-1:0]  cur_start_r, gedges_r, ledges_r;
  logic [DEG_W-1:0]  cur_deg_r;
  logic [ID_W-1:0]   psrc_r, osrc_r, pcur_r;
  logic [ID_W-1:0]   vid_r, fill_last_r;
  logic              fill_pend_r, cut_r, flushing_r;
  logic [FC_W-1:0]   fcnt_r;
  logic [ADDR_W-1:0] plo_r;
  logic [ID_W-1:0]   phi_r;
  logic [ID_W-1:0]   offs_r;
  logic [IDX_W-1:0]  vstart_r;
  logic [DEG_W-1:0]  vdeg_r;
  logic              res_valid_r;
  res_t              res_r;

  logic              div_start, div_done;
  logic [ID_W-1:0]   div_a, div_q, div_rem;
  logic              pv_zero;
  logic [ID_W-1:0]   q_eff, r_eff;
  logic [ID_W-1:0]   div_arg_r;
  logic              fill_more, fill_at_cap;

  assign pv_zero = (part_vertices == '0);
  assign q_eff   = pv_zero ? '0 : div_q;
  assign r_eff   = pv_zero ? div_arg_r : div_rem;
  assign div_a   = div_arg_r;

  // more filler ids remain after the current record; cap reached
  assign fill_more   = fill_pend_r && (vid_r != fill_last_r);
  assign fill_at_cap = (fcnt_r == FC_W'(MAX_FILL));

  secw_divider u_div (
    .clk, .rst_n,
    .start(div_start), .dividend(div_a), .divisor(part_vertices),
    .done(div_done), .quot(div_q), .rem(div_rem)
  );

  assign item_ready = (state_r == S_IDLE) && !res_valid_r;
  assign res_valid  = res_valid_r;
  assign res        = res_r;

  logic fire_out;
  assign fire_out = res_valid_r && res_ready;

  logic div_go_r;
  assign div_start = div_go_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      started_r   <= 1'b0;
      cur_src_r   <= '0;
      cur_start_r <= '0;
      cur_deg_r   <= '0;
      gedges_r    <= '0;
      ledges_r    <= '0;
      max_dest_r  <= '0;
      res_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      if (fire_out) res_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (item_valid && item_ready) begin
            it_r  <= item;
            cut_r <= 1'b0;
            if (item.cmd == CMD_FINISH) begin
              if (started_r) begin
                flushing_r  <= 1'b1;
                vid_r       <= cur_src_r;
                vstart_r    <= cur_start_r;
                vdeg_r      <= cur_deg_r;
                fill_pend_r <= (cur_src_r < max_dest_r);
                fill_last_r <= max_dest_r;
                fcnt_r      <= '0;
                div_arg_r   <= cur_src_r;
                div_go_r    <= 1'b1;
                state_r     <= S_VDIV;
              end
            end else begin
              flushing_r <= 1'b0;
              if (item.dst > max_dest_r) max_dest_r <= item.dst;
              div_arg_r <= item.src;
              div_go_r  <= 1'b1;
              state_r   <= S_DIVA;
            end
          end
        end
        S_DIVA: begin
          if (div_done) begin
            psrc_r    <= q_eff;
            osrc_r    <= r_eff;
            div_arg_r <= cur_src_r;
            div_go_r  <= 1'b1;
            state_r   <= S_DIVB;
          end
        end
        S_DIVB: begin
          if (div_done) begin
            pcur_r <= q_eff;
            if (!started_r) begin
              started_r   <= 1'b1;
              cur_src_r   <= it_r.src;
              cur_start_r <= ledges_r;
              cur_deg_r   <= DEG_W'(1);
              state_r     <= S_EMUL;
            end else if (it_r.src == cur_src_r) begin
              if (cur_deg_r != DEG_MAX) cur_deg_r <= cur_deg_r + 1'b1;
              state_r <= S_EMUL;
            end else begin
              state_r <= S_VTX;
            end
          end
        end
        S_VTX: begin
          // finished vertex record, then fills, then the new edge
          vid_r       <= cur_src_r;
          vstart_r    <= cur_start_r;
          vdeg_r      <= cur_deg_r;
          fill_pend_r <= (it_r.src > cur_src_r + 1'b1) && (cur_src_r != '1);
          fill_last_r <= it_r.src - 1'b1;
          fcnt_r      <= '0;
          div_arg_r   <= cur_src_r;
          div_go_r    <= 1'b1;
          state_r     <= S_VDIV;
        end
        S_VDIV: begin
          // partition term split into two 32-bit partial products
          if (div_done) begin
            offs_r  <= r_eff;
            plo_r   <= {32'b0, q_eff} * {32'b0, part_stride[ID_W-1:0]};
            phi_r   <= q_eff * part_stride[ADDR_W-1:ID_W];
            state_r <= S_VMUL;
          end
        end
        S_VMUL: begin
          if (!res_valid_r || fire_out) begin
            res_valid_r         <= 1'b1;
            res_r.is_vertex     <= 1'b1;
            res_r.ref_id        <= vid_r;
            res_r.list_start    <= vstart_r;
            res_r.degree        <= vdeg_r;
            // on a flush the last vertex record closes the beat
            res_r.run_last      <= flushing_r && (!fill_more || fill_at_cap);
            res_r.fill_cut      <= flushing_r && fill_more && fill_at_cap;
            res_r.addr <= vertices_split ?
              vertex_base + {28'b0, offs_r, 4'b0} + plo_r + {phi_r, 32'b0} :
              vertex_base + {28'b0, vid_r, 4'b0};
            state_r <= S_VOUT;
          end
        end
        S_VOUT: begin
          if (fill_more) begin
            state_r <= S_FILL;
          end else begin
            fill_pend_r <= 1'b0;
            if (flushing_r) begin
              started_r   <= 1'b0;
              cur_src_r   <= '0;
              cur_start_r <= '0;
              cur_deg_r   <= '0;
              gedges_r    <= '0;
              ledges_r    <= '0;
              max_dest_r  <= '0;
              state_r     <= S_WAIT;
            end else begin
              if (edges_split && (osrc_r == '0 || psrc_r > pcur_r)) begin
                ledges_r    <= '0;
                cur_start_r <= '0;
              end else begin
                cur_start_r <= ledges_r;
              end
              cur_src_r <= it_r.src;
              cur_deg_r <= DEG_W'(1);
              state_r   <= S_EMUL;
            end
          end
        end
        S_FILL: begin
          if (fill_at_cap) begin
            cut_r       <= 1'b1;
            fill_pend_r <= 1'b0;
            state_r     <= S_VOUT;
          end else if (!res_valid_r || fire_out) begin
            fcnt_r      <= fcnt_r + 1'b1;
            vid_r       <= vid_r + 1'b1;
            vstart_r    <= '0;
            vdeg_r      <= '0;
            div_arg_r   <= vid_r + 1'b1;
            div_go_r    <= 1'b1;
            state_r     <= S_VDIV;
          end
        end
        S_EMUL: begin
          plo_r   <= {32'b0, psrc_r} * {32'b0, part_stride[ID_W-1:0]};
          phi_r   <= psrc_r * part_stride[ADDR_W-1:ID_W];
          state_r <= S_EOUT;
        end
        S_EOUT: begin
          if (!res_valid_r || fire_out) begin
            res_valid_r      <= 1'b1;
            res_r.is_vertex  <= 1'b0;
            res_r.ref_id     <= it_r.dst;
            res_r.list_start <= '0;
            res_r.degree     <= '0;
            res_r.run_last   <= 1'b1;
            res_r.fill_cut   <= cut_r;
            res_r.addr <= edges_split ?
              edge_base + {13'b0, ledges_r, 3'b0} + plo_r + {phi_r, 32'b0} :
              edge_base + {13'b0, gedges_r, 3'b0};
            ledges_r <= ledges_r + 1'b1;
            gedges_r <= gedges_r + 1'b1;
            state_r  <= S_IDLE;
          end
        end
        S_WAIT: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> design/secw_front.sv
// Front end: holds configuration registers and takes input beats into the queue.
// Depends on secw_pkg.
module secw_front import secw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  item_t                in_item,
  output logic                 q_valid,
  input  logic                 q_ready,
  output item_t                q_item,
  output logic [ADDR_W-1:0]    edge_base,
  output logic [ADDR_W-1:0]    vertex_base,
  output logic [ID_W-1:0]      part_vertices,
  output logic [ADDR_W-1:0]    part_stride,
  output logic                 edges_split,
  output logic                 vertices_split
);
  logic [ADDR_W-1:0] eb_r, vb_r, ps_r;
  logic [ID_W-1:0]   pv_r;
  logic              es_r, vs_r;

  assign cfg_ready      = 1'b1;
  assign in_ready       = q_ready;
  assign q_valid        = in_valid;
  assign q_item         = in_item;
  assign edge_base      = eb_r;
  assign vertex_base    = vb_r;
  assign part_vertices  = pv_r;
  assign part_stride    = ps_r;
  assign edges_split    = es_r;
  assign vertices_split = vs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eb_r <= '0;
      vb_r <= '0;
      pv_r <= ID_W'(65536);
      ps_r <= ADDR_W'(268435456);
      es_r <= 1'b0;
      vs_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_EDGE_BASE:   eb_r <= cfg_data;
        REG_VERTEX_BASE: vb_r <= cfg_data;
        REG_PART_VERTS:  pv_r <= cfg_data[ID_W-1:0];
        REG_PART_STRIDE: ps_r <= cfg_data;
        REG_EDGES_SPLIT: es_r <= cfg_data[0];
        REG_VERTS_SPLIT: vs_r <= cfg_data[0];
        default: ;
      endcase
    end
  end
endmodule

>>> design/sorted_edge_list_to_csr_writer.sv
// Sorted edge list to CSR writer: edges in, CSR record writes out.
// An edge without a source change runs two serial divides by part_vertices;
// a source change adds a divide and a result beat for each vertex or filler
// record written. One item is in work at a time.
// Reset: synchronous, active low; clears stream state and loads register defaults.
module sorted_edge_list_to_csr_writer import secw_pkg::*; #(
  parameter int unsigned MAX_FILL = MAX_FILL_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  input  logic [ID_W-1:0]      in_src_vertex,
  input  logic [ID_W-1:0]      in_dst_vertex,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_is_vertex,
  output logic [ADDR_W-1:0]    out_write_addr,
  output logic [ID_W-1:0]      out_ref_id,
  output logic [IDX_W-1:0]     out_list_start,
  output logic [DEG_W-1:0]     out_out_degree,
  output logic                 out_run_last,
  output logic                 out_fill_cut
);
  item_t             in_item, q_wr, q_rd;
  logic              qw_valid, qw_ready, qr_valid, qr_ready;
  logic [ADDR_W-1:0] eb, vb, ps;
  logic [ID_W-1:0]   pv;
  logic              es, vs;
  res_t              res;

  assign in_item = '{cmd: in_cmd, src: in_src_vertex, dst: in_dst_vertex};

  secw_front u_front (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_item,
    .q_valid(qw_valid), .q_ready(qw_ready), .q_item(q_wr),
    .edge_base(eb), .vertex_base(vb), .part_vertices(pv), .part_stride(ps),
    .edges_split(es), .vertices_split(vs)
  );

  // queue decouples intake from record generation
  secw_fifo u_fifo (
    .clk, .rst_n, .wr_valid(qw_valid), .wr_ready(qw_ready), .wr_data(q_wr),
    .rd_valid(qr_valid), .rd_ready(qr_ready), .rd_data(q_rd)
  );

  secw_back #(.MAX_FILL(MAX_FILL)) u_back (
    .clk, .rst_n, .item_valid(qr_valid), .item_ready(qr_ready), .item(q_rd),
    .edge_base(eb), .vertex_base(vb), .part_vertices(pv), .part_stride(ps),
    .edges_split(es), .vertices_split(vs),
    .res_valid(out_valid), .res_ready(out_ready), .res
  );

  assign out_is_vertex  = res.is_vertex;
  assign out_write_addr = res.addr;
  assign out_ref_id     = res.ref_id;
  assign out_list_start = res.list_start;
  assign out_out_degree = res.degree;
  assign out_run_last   = res.run_last;
  assign out_fill_cut   = res.fill_cut;
endmodule
